FILE: design/pcu_pkg.sv
// Package for the packed code point to UTF-8 converter.
// Holds the decoder phase codes, shared structs and the UTF-8 encode function.
// No dependencies.
package pcu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 32;
  localparam int unsigned CntW   = 4;
  localparam int unsigned MaxOut = 4;
  localparam int unsigned RemW   = 3;

  localparam logic [ByteW-1:0] PairBias = 8'h40;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_MULTI = 3'b010,
    PH_PAIR  = 3'b100
  } phase_e;

  typedef logic [MaxOut-1:0][ByteW-1:0] out_bytes_t;

  // finished code point leaving the decoder
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] cp;
  } dec_res_t;

  typedef struct packed {
    out_bytes_t      bytes;
    logic [RemW-1:0] cnt;
  } enc_res_t;

  // unchecked UTF-8 rule, lead byte of the 4-byte form truncated to 8 bits
  function automatic enc_res_t utf8_encode(input logic [CpW-1:0] cp);
    enc_res_t r;
    r.bytes = '0;
    if (cp < 32'h80) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = RemW'(1);
    end else if (cp < 32'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = RemW'(2);
    end else if (cp < 32'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = RemW'(3);
    end else begin
      r.bytes[0] = cp[25:18] | 8'hF0;
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = RemW'(4);
    end
    return r;
  endfunction

endpackage

FILE: design/pcu_decode.sv
// Decoder state machine: collects multi-byte and pair forms into code points.
// Depends on pcu_pkg.
module pcu_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [pcu_pkg::ByteW-1:0] byte_i,
  input  logic                      token_end_i,
  output pcu_pkg::dec_res_t         res_o
);
  import pcu_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   left_q, left_d;
  logic [CpW-1:0]    code_q, code_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic [CpW-1:0]    acc_shift;
  logic [CntW-1:0]   left_dec;
  logic [ByteW-1:0]  pair_hi;

  assign acc_shift = {code_q[CpW-8:0], byte_i[6:0]};
  assign left_dec  = left_q - CntW'(1);
  assign pair_hi   = first_q - PairBias;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    code_d     = code_q;
    first_d    = first_q;
    res_o.emit = 1'b0;
    res_o.cp   = '0;
    unique case (phase_q)
      PH_MULTI: begin
        code_d = acc_shift;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d    = PH_IDLE;
          res_o.emit = (acc_shift != '0);
          res_o.cp   = acc_shift;
          code_d     = '0;
        end
      end
      PH_PAIR: begin
        res_o.emit = 1'b1;
        res_o.cp   = {16'h0, pair_hi, byte_i};
        phase_d    = PH_IDLE;
        first_d    = '0;
      end
      default: begin
        phase_d = PH_IDLE;
        if (!byte_i[7]) begin
          res_o.emit = 1'b1;
          res_o.cp   = {24'h0, byte_i};
        end else if (byte_i[7:4] == 4'hE) begin
          if (byte_i[3:0] != 4'h0) begin
            phase_d = PH_MULTI;
            left_d  = byte_i[3:0];
            code_d  = '0;
          end
        end else begin
          phase_d = PH_PAIR;
          first_d = byte_i;
        end
      end
    endcase
    if (token_end_i) begin
      phase_d = PH_IDLE;
      left_d  = '0;
      code_d  = '0;
      first_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= '0;
      code_q  <= '0;
      first_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      code_q  <= code_d;
      first_q <= first_d;
    end
  end

  a_multi_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MULTI) |-> (left_q != '0))
    else $error("multi-byte phase with zero count");

  a_pair_high_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAIR) |-> first_q[7])
    else $error("pair phase without a high lead byte");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (left_q == '0 && code_q == '0 && first_q == '0))
    else $error("idle phase with leftover state");

endmodule

FILE: design/pcu_serial.sv
// Result register: holds one item's UTF-8 bytes, sends one per cycle unless stalled.
// Depends on pcu_pkg.
module pcu_serial (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  pcu_pkg::dec_res_t         res_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [pcu_pkg::ByteW-1:0] out_byte_o,
  output logic                      last_of_run_o,
  output logic                      free_o
);
  import pcu_pkg::*;

  out_bytes_t      bytes_q, bytes_d;
  logic [RemW-1:0] rem_q, rem_d;
  enc_res_t        enc;
  logic            take;

  assign enc           = utf8_encode(res_i.cp);
  assign out_valid_o   = (rem_q != '0);
  assign out_byte_o    = bytes_q[0];
  assign last_of_run_o = (rem_q == RemW'(1));
  assign take          = out_valid_o && !out_stall_i;
  assign free_o        = (rem_q == '0) || (last_of_run_o && take);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    if (load_i) begin
      bytes_d = enc.bytes;
      rem_d   = res_i.emit ? enc.cnt : '0;
    end else if (take) begin
      bytes_d = {ByteW'(0), bytes_q[MaxOut-1:1]};
      rem_d   = rem_q - RemW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= RemW'(MaxOut))
    else $error("result count out of range");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register loaded while bytes remain");

  a_take_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !load_i) |=> (rem_q == $past(rem_q) - RemW'(1)))
    else $error("byte count did not step down after a transfer");

endmodule

FILE: design/packed_codepoint_to_utf8.sv
// Packed code point to UTF-8 converter, top level.
// An input item passes the input register and the decoder; its first UTF-8 byte leaves the result register.
// Throughput: one input item per cycle when it yields at most one byte and the output
// is not stalled; an item of N bytes (N from 0 to 4) holds the single-byte result port till sent.
// Reset: rst_ni async active low; decoder returns to idle, both registers empty.
// Depends on pcu_pkg, pcu_decode and pcu_serial.
module packed_codepoint_to_utf8 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [pcu_pkg::ByteW-1:0] in_byte_i,
  input  logic                      token_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pcu_pkg::ByteW-1:0] out_byte_o,
  output logic                      last_of_run_o
);
  import pcu_pkg::*;

  logic             vld_q;
  logic [ByteW-1:0] byte_q;
  logic             te_q;
  logic             res_free;
  logic             adv;
  logic             in_take;
  dec_res_t         dec_res;

  assign adv        = vld_q && res_free;
  assign in_stall_o = vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_take || adv) begin
      vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_byte_i;
      te_q   <= token_end_i;
    end
  end

  pcu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .byte_i      (byte_q),
    .token_end_i (te_q),
    .res_o       (dec_res)
  );

  pcu_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv),
    .res_i         (dec_res),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .free_o        (res_free)
  );

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q && out_valid_o))
    else $error("input stalled with no item waiting on the result side");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> vld_q)
    else $error("accepted item not held in the input register");

endmodule
